>>> design/lzw_dictionary_search_insert_top_defines.svh
// Assertion macros for the LZW dictionary search/insert block.
// Used by lzw_dictionary_search_insert_top; expects clk and rst_n in scope.
`ifndef LZW_DICTIONARY_SEARCH_INSERT_TOP_DEFINES_SVH
`define LZW_DICTIONARY_SEARCH_INSERT_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LZWDSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define LZWDSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lzwdsi_pkg.sv
// Shared types, constants and microcode for the LZW dictionary block.
// No dependencies; used by lzwdsi_dpath and lzw_dictionary_search_insert_top.
package lzwdsi_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int ALPHABET     = 256;
  localparam int CODE_W       = $clog2(DICT_ENTRIES);
  localparam int NF_W         = CODE_W + 1;
  localparam int BYTE_W       = 8;
  localparam int PC_W         = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix_code;
    logic              no_prefix;
    logic [BYTE_W-1:0] next_byte;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              existed;
    logic              full_res;
  } out_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_IN_FIRE,
    COND_NO_PREFIX,
    COND_ROOT_ZERO,
    COND_EQ,
    COND_CUR_NZ,
    COND_FULL,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_BYTE,
    RES_FOUND,
    RES_NEW,
    RES_FULL
  } res_sel_t;

  // One control word of the sequencer program
  typedef struct packed {
    logic     ld_in;
    logic     rd_root;
    logic     ld_cur_root;
    logic     rd_node;
    logic     mv_cur;
    logic     wr_new;
    logic     wr_link;
    logic     wr_root_pfx;
    logic     nf_inc;
    logic     emit;
    res_sel_t res_sel;
    cond_t    cond;
    pc_t      target;
  } ctl_t;

  // Datapath flags tested by jump conditions
  typedef struct packed {
    logic no_prefix;
    logic root_zero;
    logic eq;
    logic cur_nz;
    logic full;
  } stat_t;

  // Program step addresses
  localparam pc_t ST_IDLE       = 4'd0;
  localparam pc_t ST_DISPATCH   = 4'd1;
  localparam pc_t ST_ROOT       = 4'd2;
  localparam pc_t ST_RDNODE     = 4'd3;
  localparam pc_t ST_CMP        = 4'd4;
  localparam pc_t ST_DESCEND    = 4'd5;
  localparam pc_t ST_LEAF_CHK   = 4'd6;
  localparam pc_t ST_LEAF_WR    = 4'd7;
  localparam pc_t ST_LEAF_LINK  = 4'd8;
  localparam pc_t ST_ROOT_CHK   = 4'd9;
  localparam pc_t ST_ROOT_WR    = 4'd10;
  localparam pc_t ST_ROOT_LINK  = 4'd11;
  localparam pc_t ST_FOUND      = 4'd12;
  localparam pc_t ST_BYTE       = 4'd13;
  localparam pc_t ST_FULL       = 4'd14;
  localparam pc_t ST_EMIT       = 4'd15;

  // Force a byte into the alphabet
  function automatic logic [BYTE_W-1:0] clamp_byte(logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] wide;
    wide = {1'b0, b};
    if (wide >= (BYTE_W+1)'(ALPHABET)) begin
      return BYTE_W'(ALPHABET - 1);
    end
    return b;
  endfunction

  // Program ROM: one control word per step, fall-through to pc + 1
  function automatic ctl_t ucode(pc_t pc);
    ctl_t w;
    w = '0;
    w.res_sel = RES_NONE;
    w.cond    = COND_NEVER;
    case (pc)
      ST_IDLE: begin
        w.ld_in = 1'b1; w.cond = COND_NOT_IN_FIRE; w.target = ST_IDLE;
      end
      ST_DISPATCH: begin
        w.rd_root = 1'b1; w.cond = COND_NO_PREFIX; w.target = ST_BYTE;
      end
      ST_ROOT: begin
        w.ld_cur_root = 1'b1; w.cond = COND_ROOT_ZERO; w.target = ST_ROOT_CHK;
      end
      ST_RDNODE: begin
        w.rd_node = 1'b1;
      end
      ST_CMP: begin
        w.mv_cur = 1'b1; w.cond = COND_EQ; w.target = ST_FOUND;
      end
      ST_DESCEND: begin
        w.cond = COND_CUR_NZ; w.target = ST_RDNODE;
      end
      ST_LEAF_CHK: begin
        w.cond = COND_FULL; w.target = ST_FULL;
      end
      ST_LEAF_WR: begin
        w.wr_new = 1'b1;
      end
      ST_LEAF_LINK: begin
        w.wr_link = 1'b1; w.nf_inc = 1'b1; w.res_sel = RES_NEW;
        w.cond = COND_ALWAYS; w.target = ST_EMIT;
      end
      ST_ROOT_CHK: begin
        w.cond = COND_FULL; w.target = ST_FULL;
      end
      ST_ROOT_WR: begin
        w.wr_new = 1'b1;
      end
      ST_ROOT_LINK: begin
        w.wr_root_pfx = 1'b1; w.nf_inc = 1'b1; w.res_sel = RES_NEW;
        w.cond = COND_ALWAYS; w.target = ST_EMIT;
      end
      ST_FOUND: begin
        w.res_sel = RES_FOUND; w.cond = COND_ALWAYS; w.target = ST_EMIT;
      end
      ST_BYTE: begin
        w.res_sel = RES_BYTE; w.cond = COND_ALWAYS; w.target = ST_EMIT;
      end
      ST_FULL: begin
        w.res_sel = RES_FULL;
      end
      ST_EMIT: begin
        w.emit = 1'b1; w.cond = COND_OUT_BUSY; w.target = ST_EMIT;
      end
      default: begin
        w.cond = COND_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/lzwdsi_dpath.sv
// Datapath of the LZW dictionary: tree memories, walk registers, result.
// Depends on lzwdsi_pkg; driven by the sequencer in the top level.
module lzwdsi_dpath
  import lzwdsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic              in_fire,
  input  in_t               in_data,
  input  logic              clr_en,
  input  logic [CODE_W-1:0] clr_addr,
  output stat_t             stat,
  output out_t              res
);

  // Dictionary stores
  logic [CODE_W-1:0] root_mem  [DICT_ENTRIES];
  logic [BYTE_W-1:0] ebyte_mem [DICT_ENTRIES];
  logic [CODE_W-1:0] left_mem  [DICT_ENTRIES];
  logic [CODE_W-1:0] right_mem [DICT_ENTRIES];

  logic [CODE_W-1:0] pfx_r;
  logic              nopfx_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CODE_W-1:0] cur_r;
  logic [CODE_W-1:0] last_r;
  logic              dir_left_r;
  logic [NF_W-1:0]   nf_r;
  logic [CODE_W-1:0] root_q_r;
  logic [BYTE_W-1:0] ebyte_q_r;
  logic [CODE_W-1:0] left_q_r;
  logic [CODE_W-1:0] right_q_r;
  out_t              res_r;

  logic [CODE_W-1:0] nf_code;
  logic              is_lt;
  logic              root_we;
  logic [CODE_W-1:0] root_wa;
  logic [CODE_W-1:0] root_wd;
  logic              left_we;
  logic              right_we;
  logic [CODE_W-1:0] link_wa;
  logic [CODE_W-1:0] link_wd;

  assign nf_code = nf_r[CODE_W-1:0];
  assign is_lt   = byte_r < ebyte_q_r;

  // Flags for the sequencer
  assign stat.no_prefix = nopfx_r;
  assign stat.root_zero = (root_q_r == '0);
  assign stat.eq        = (byte_r == ebyte_q_r);
  assign stat.cur_nz    = (cur_r != '0);
  assign stat.full      = (nf_r >= NF_W'(DICT_ENTRIES));

  // Root store write port: clearing pass, new-entry clear, or root link
  always_comb begin
    root_we = 1'b0;
    root_wa = nf_code;
    root_wd = '0;
    if (clr_en) begin
      root_we = 1'b1;
      root_wa = clr_addr;
    end else if (ctl.wr_new) begin
      root_we = 1'b1;
    end else if (ctl.wr_root_pfx) begin
      root_we = 1'b1;
      root_wa = pfx_r;
      root_wd = nf_code;
    end
  end

  // Child link write port: zero a new entry, or hang it under the last node
  always_comb begin
    left_we  = ctl.wr_new | (ctl.wr_link & dir_left_r);
    right_we = ctl.wr_new | (ctl.wr_link & ~dir_left_r);
    link_wa  = ctl.wr_new ? nf_code : last_r;
    link_wd  = ctl.wr_new ? '0 : nf_code;
  end

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[root_wa] <= root_wd;
    end
    if (ctl.rd_root) begin
      root_q_r <= root_mem[pfx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      ebyte_mem[nf_code] <= byte_r;
    end
    if (ctl.rd_node) begin
      ebyte_q_r <= ebyte_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[link_wa] <= link_wd;
    end
    if (ctl.rd_node) begin
      left_q_r <= left_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[link_wa] <= link_wd;
    end
    if (ctl.rd_node) begin
      right_q_r <= right_mem[cur_r];
    end
  end

  // Latch request, walk pointer and direction
  always_ff @(posedge clk) begin
    if (ctl.ld_in && in_fire) begin
      pfx_r   <= in_data.prefix_code;
      nopfx_r <= in_data.no_prefix;
      byte_r  <= clamp_byte(in_data.next_byte);
    end
    if (ctl.ld_cur_root) begin
      cur_r <= root_q_r;
    end else if (ctl.mv_cur && !stat.eq) begin
      cur_r      <= is_lt ? left_q_r : right_q_r;
      dir_left_r <= is_lt;
    end
    if (ctl.rd_node) begin
      last_r <= cur_r;
    end
  end

  // Advance the free pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= NF_W'(ALPHABET);
    end else if (ctl.nf_inc) begin
      nf_r <= nf_r + NF_W'(1);
    end
  end

  // Build the result
  always_ff @(posedge clk) begin
    case (ctl.res_sel)
      RES_BYTE:  res_r <= '{code: CODE_W'(byte_r), existed: 1'b1, full_res: 1'b0};
      RES_FOUND: res_r <= '{code: cur_r, existed: 1'b1, full_res: 1'b0};
      RES_NEW:   res_r <= '{code: nf_code, existed: 1'b0, full_res: 1'b0};
      RES_FULL:  res_r <= '{code: '0, existed: 1'b0, full_res: 1'b1};
      default:   res_r <= res_r;
    endcase
  end

  assign res = res_r;

endmodule

>>> design/lzw_dictionary_search_insert_top.sv
// Flow: a byte without prefix is answered as its own code; otherwise the root of the
// prefix is read and the tree walked with one registered node read per visited node,
// ending found, inserted under the last node, or refused when the dictionary is full;
// an empty tree inserts at the root, or is refused when full. A held result stalls the sequencer.
// Reset: synchronous, active low; afterwards a pass clears all 4096 entries of the root
// store, during which in_ready stays low.
`include "lzw_dictionary_search_insert_top_defines.svh"

module lzw_dictionary_search_insert_top
  import lzwdsi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  pc_t             pc_r;
  pc_t             pc_nxt;
  logic [NF_W-1:0] clr_cnt_r;
  logic            clearing;
  logic            out_valid_r;
  out_t            out_data_r;
  ctl_t            ctl;
  stat_t           stat;
  out_t            res;
  logic            in_fire;
  logic            out_busy;
  logic            take;

  assign clearing = (clr_cnt_r != NF_W'(DICT_ENTRIES));
  assign in_ready = (pc_r == ST_IDLE) && !clearing;
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;
  assign ctl      = ucode(pc_r);

  // Evaluate jump condition and pick next step
  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:      take = 1'b1;
      COND_NOT_IN_FIRE: take = !in_fire;
      COND_NO_PREFIX:   take = stat.no_prefix;
      COND_ROOT_ZERO:   take = stat.root_zero;
      COND_EQ:          take = stat.eq;
      COND_CUR_NZ:      take = stat.cur_nz;
      COND_FULL:        take = stat.full;
      COND_OUT_BUSY:    take = out_busy;
      default:          take = 1'b0;
    endcase
    pc_nxt = take ? ctl.target : pc_r + pc_t'(1);
  end

  // Step counter; hold in idle while the root store clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else if (!clearing) begin
      pc_r <= pc_nxt;
    end
  end

  // Root store clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + NF_W'(1);
    end
  end

  // Output register: load on emit when free, drop on accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && !out_busy) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lzwdsi_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .clr_en   (clearing),
    .clr_addr (clr_cnt_r[CODE_W-1:0]),
    .stat     (stat),
    .res      (res)
  );

  `LZWDSI_ASSERT_SAME(a_clear_idle, clearing, (pc_r == ST_IDLE) && !in_ready, "input taken while clearing")
  `LZWDSI_ASSERT_NEXT(a_accept_dispatch, in_fire, pc_r == ST_DISPATCH, "accepted beat not dispatched")
  `LZWDSI_ASSERT_SAME(a_full_shape, out_valid_r && out_data_r.full_res, (out_data_r.code == '0) && !out_data_r.existed, "full result carries a code")
  `LZWDSI_ASSERT_SAME(a_new_code, out_valid_r && !out_data_r.existed && !out_data_r.full_res, out_data_r.code >= CODE_W'(ALPHABET), "new entry code inside alphabet")

endmodule
